@@ design/rv64_subset_instruction_core_macros.svh @@
// Assertion helpers shared by the core. Each expects clk and rst_n in scope.
`ifndef RV64_SUBSET_INSTRUCTION_CORE_MACROS_SVH
`define RV64_SUBSET_INSTRUCTION_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define RSIC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger
`define RSIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rsic_pkg.sv @@
`default_nettype none

package rsic_pkg;

    // Machine widths
    localparam int XLEN        = 64;
    localparam int ILEN        = 32;
    localparam int REG_COUNT   = 32;
    localparam int REG_AW      = 5;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 264;
    localparam int OUT_TUSER_W = 3;

    // Default data store depth in double words (power of two)
    localparam int DATA_DEPTH_DEF = 1024;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    // ALU funct3 codes
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct7 that turns ADD into SUB
    localparam logic [6:0] F7_SUB = 7'h20;

endpackage

`default_nettype wire

@@ design/rv64_subset_instruction_core.sv @@
// Channel   | Dir | Signals                          | Item
// ----------+-----+----------------------------------+-----------------------------------
// s_axis    | in  | s_axis_tvalid/tready/tdata[31:0] | one instruction word
// m_axis    | out | m_axis_tvalid/tready/tdata/tuser | one execution result
// cfg       | in  | cfg_valid/cfg_ready/cfg_data     | start_pc (also loads the PC)
//
// An item waits in decode/execute (operands from the register file read at acceptance)
// until the output register is free, and then sits in the output register.
// A new item is accepted every cycle while the output side keeps taking results.
// Register file and data store are synchronous memories with registered reads; write-backs are
// forwarded from the output stage and bypassed into the read port at the write edge.
// Reset clears the PC to zero and marks all registers as zero; no clearing pass.
// A stalled output holds both stages; the data store index is address bits [3 +: log2 depth].
`default_nettype none
`include "rv64_subset_instruction_core_macros.svh"

module rv64_subset_instruction_core
    import rsic_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // tdata: instruction[31:0]
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // tdata: inst_pc[63:0], next_pc[127:64], dest_index[132:128],
    //        dest_value[196:133], mem_address[260:197], zero[263:261]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: branch_taken[0], reg_written[1], store_done[2]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [XLEN-1:0]        cfg_data
);

    localparam int DATA_AW = $clog2(DATA_DEPTH);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [XLEN-1:0]      rf_mem [REG_COUNT];
    logic [XLEN-1:0]      data_mem [DATA_DEPTH];

    logic [REG_COUNT-1:0] rf_valid_reg, rf_valid_next;
    logic [XLEN-1:0]      pc_reg, pc_next;

    // Decode/execute stage
    logic                 d_valid_reg, d_valid_next;
    logic [ILEN-1:0]      d_inst_reg;
    logic [XLEN-1:0]      rs1_raw_reg, rs2_raw_reg, byp_data_reg;
    logic                 rs1_ok_reg, rs2_ok_reg, rs1_byp_reg, rs2_byp_reg;

    // Output stage
    logic                 m_valid_reg, m_valid_next;
    logic                 m_wb_pend_reg, m_wb_pend_next;
    logic [XLEN-1:0]      m_inst_pc_reg, m_next_pc_reg, m_alu_reg, m_addr_reg;
    logic                 m_taken_reg, m_wen_reg, m_load_reg, m_store_reg;
    logic [REG_AW-1:0]    m_rd_reg;
    logic [XLEN-1:0]      mem_rdata_reg;
    logic [XLEN-1:0]      m_dest_value;

    // Handshakes and flow
    logic                 s_accept, d_adv, m_free;
    logic [REG_AW-1:0]    s_rs1, s_rs2;

    // Decode fields
    logic [6:0]           opc, f7;
    logic [2:0]           f3;
    logic [REG_AW-1:0]    rd, rs1, rs2;
    logic [XLEN-1:0]      imm_i, imm_s, imm_b;
    logic [XLEN-1:0]      rs1_val, rs2_val, alu_b, alu_sum, alu_diff, alu_out;
    logic [XLEN-1:0]      addr_sum, pc_plus4, br_target;
    logic                 br_eq, br_lt, br_ltu, br_cond;
    logic                 d_wen, d_load, d_store, d_taken, d_sub;
    logic [XLEN-1:0]      d_addr, d_next_pc;
    logic [DATA_AW-1:0]   d_index;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign m_free        = !m_valid_reg || m_axis_tready;
    assign d_adv         = d_valid_reg && m_free;
    assign s_axis_tready = !d_valid_reg || d_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign s_rs1 = s_axis_tdata[19:15];
    assign s_rs2 = s_axis_tdata[24:20];

    // ------------------------------------------------------------------
    // Register file: two sync reads at acceptance, one write-back port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (m_wb_pend_reg)
        begin
            rf_mem[m_rd_reg] <= m_dest_value;
        end
        if (s_accept)
        begin
            rs1_raw_reg  <= rf_mem[s_rs1];
            rs2_raw_reg  <= rf_mem[s_rs2];
            byp_data_reg <= m_dest_value;
            d_inst_reg   <= s_axis_tdata;
        end
    end

    // Capture validity and same-edge write bypass per operand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs1_ok_reg  <= 1'b0;
            rs2_ok_reg  <= 1'b0;
            rs1_byp_reg <= 1'b0;
            rs2_byp_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            rs1_ok_reg  <= rf_valid_reg[s_rs1];
            rs2_ok_reg  <= rf_valid_reg[s_rs2];
            rs1_byp_reg <= m_wb_pend_reg && (m_rd_reg == s_rs1);
            rs2_byp_reg <= m_wb_pend_reg && (m_rd_reg == s_rs2);
        end
    end

    // Mark written registers; x0 is never written so it always reads zero
    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (m_wb_pend_reg)
        begin
            rf_valid_next[m_rd_reg] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign opc = d_inst_reg[6:0];
    assign rd  = d_inst_reg[11:7];
    assign f3  = d_inst_reg[14:12];
    assign rs1 = d_inst_reg[19:15];
    assign rs2 = d_inst_reg[24:20];
    assign f7  = d_inst_reg[31:25];

    assign imm_i = {{(XLEN-12){d_inst_reg[31]}}, d_inst_reg[31:20]};
    assign imm_s = {{(XLEN-12){d_inst_reg[31]}}, d_inst_reg[31:25], d_inst_reg[11:7]};
    assign imm_b = {{(XLEN-13){d_inst_reg[31]}}, d_inst_reg[31], d_inst_reg[7],
                    d_inst_reg[30:25], d_inst_reg[11:8], 1'b0};

    // Operand select: forward from output stage, then write bypass, then file
    always_comb
    begin
        if (m_valid_reg && m_wen_reg && (m_rd_reg == rs1))
            rs1_val = m_dest_value;
        else if (rs1_byp_reg)
            rs1_val = byp_data_reg;
        else if (rs1_ok_reg)
            rs1_val = rs1_raw_reg;
        else
            rs1_val = '0;

        if (m_valid_reg && m_wen_reg && (m_rd_reg == rs2))
            rs2_val = m_dest_value;
        else if (rs2_byp_reg)
            rs2_val = byp_data_reg;
        else if (rs2_ok_reg)
            rs2_val = rs2_raw_reg;
        else
            rs2_val = '0;
    end

    // ------------------------------------------------------------------
    // Execute: ALU, address add, branch compare
    // ------------------------------------------------------------------
    assign d_sub    = (opc == OPC_OP) && (f7 == F7_SUB);
    assign alu_b    = (opc == OPC_OP) ? rs2_val : imm_i;
    assign alu_sum  = rs1_val + alu_b;
    assign alu_diff = rs1_val - alu_b;

    always_comb
    begin
        unique case (f3)
            F3_ADD:  alu_out = d_sub ? alu_diff : alu_sum;
            F3_XOR:  alu_out = rs1_val ^ alu_b;
            F3_OR:   alu_out = rs1_val | alu_b;
            F3_AND:  alu_out = rs1_val & alu_b;
            default: alu_out = alu_sum;
        endcase
    end

    assign addr_sum  = rs1_val + ((opc == OPC_STORE) ? imm_s : imm_i);
    assign pc_plus4  = pc_reg + XLEN'(4);
    assign br_target = pc_reg + imm_b;

    assign br_eq  = (rs1_val == rs2_val);
    assign br_lt  = ($signed(rs1_val) < $signed(rs2_val));
    assign br_ltu = (rs1_val < rs2_val);

    always_comb
    begin
        unique case (f3)
            F3_BEQ:  br_cond = br_eq;
            F3_BNE:  br_cond = !br_eq;
            F3_BLT:  br_cond = br_lt;
            F3_BGE:  br_cond = !br_lt;
            F3_BLTU: br_cond = br_ltu;
            F3_BGEU: br_cond = !br_ltu;
            default: br_cond = 1'b0;
        endcase
    end

    // Opcode dispatch
    always_comb
    begin
        d_wen   = 1'b0;
        d_load  = 1'b0;
        d_store = 1'b0;
        d_taken = 1'b0;
        d_addr  = '0;
        unique case (opc)
            OPC_OP, OPC_OPIMM:
            begin
                d_wen = (rd != '0);
            end
            OPC_LOAD:
            begin
                d_wen  = (rd != '0);
                d_load = 1'b1;
                d_addr = addr_sum;
            end
            OPC_STORE:
            begin
                d_store = 1'b1;
                d_addr  = addr_sum;
            end
            OPC_BRANCH:
            begin
                d_taken = br_cond;
            end
            default:
            begin
                d_wen = 1'b0;
            end
        endcase
    end

    assign d_next_pc = d_taken ? br_target : pc_plus4;
    assign d_index   = addr_sum[3 +: DATA_AW];

    // ------------------------------------------------------------------
    // Data store: write on store, registered read on load
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (d_adv && d_store)
        begin
            data_mem[d_index] <= rs2_val;
        end
        if (d_adv && d_load)
        begin
            mem_rdata_reg <= data_mem[d_index];
        end
    end

    // ------------------------------------------------------------------
    // Output stage payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (d_adv)
        begin
            m_inst_pc_reg <= pc_reg;
            m_next_pc_reg <= d_next_pc;
            m_taken_reg   <= d_taken;
            m_rd_reg      <= rd;
            m_alu_reg     <= alu_out;
            m_load_reg    <= d_load;
            m_store_reg   <= d_store;
            m_addr_reg    <= d_addr;
        end
    end

    // Write-back value: loaded word or ALU result, zero when nothing is written
    always_comb
    begin
        if (!m_wen_reg)
            m_dest_value = '0;
        else if (m_load_reg)
            m_dest_value = mem_rdata_reg;
        else
            m_dest_value = m_alu_reg;
    end

    // ------------------------------------------------------------------
    // Control next state
    // ------------------------------------------------------------------
    always_comb
    begin
        d_valid_next = d_valid_reg;
        if (s_accept)
            d_valid_next = 1'b1;
        else if (d_adv)
            d_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (d_adv)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;

        // Write back in the cycle after entry, once the load data is in
        m_wb_pend_next = d_adv && d_wen;

        pc_next = pc_reg;
        if (cfg_valid)
            pc_next = cfg_data;
        else if (d_adv)
            pc_next = d_next_pc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_wb_pend_reg <= 1'b0;
            m_wen_reg     <= 1'b0;
            rf_valid_reg  <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            d_valid_reg   <= d_valid_next;
            m_valid_reg   <= m_valid_next;
            m_wb_pend_reg <= m_wb_pend_next;
            rf_valid_reg  <= rf_valid_next;
            pc_reg        <= pc_next;
            if (d_adv)
            begin
                m_wen_reg <= d_wen;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ports
    // ------------------------------------------------------------------
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_addr_reg, m_dest_value, m_rd_reg,
                            m_next_pc_reg, m_inst_pc_reg};
    assign m_axis_tuser  = {m_store_reg, m_wen_reg, m_taken_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RSIC_ASSERT_SAME(a_no_x0_write, m_wb_pend_reg, m_rd_reg != '0, "write-back to x0")
    `RSIC_ASSERT_SAME(a_wb_has_item, m_wb_pend_reg, m_valid_reg && m_wen_reg,
                      "write-back without a result in the output stage")
    `RSIC_ASSERT_NEXT(a_adv_fills_out, d_adv, m_valid_reg, "advanced item lost")
    `RSIC_ASSERT_NEXT(a_wen_schedules_wb, d_adv && d_wen, m_wb_pend_reg,
                      "register write not scheduled")
    `RSIC_ASSERT_SAME(a_store_no_wen, m_valid_reg, !(m_store_reg && m_wen_reg),
                      "store also writes a register")

endmodule

`default_nettype wire
